/* hw/rtl/mpq_pkg.sv */
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int ARRIVAL_BITS = 16;

    typedef enum logic [2:0] {
        OP_ENQUEUE = 3'd0,
        OP_DEQUEUE = 3'd1,
        OP_PEEK    = 3'd2,
        OP_CHANGE  = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Flags of the search wave travelling down the cell chain.
    typedef struct packed {
        logic valid;
        logic top_found;
        logic tag_found;
        logic free_found;
    } scan_flags_t;

    // Write command broadcast to all cells; the addressed cell acts, but every cell obeys clear_all.
    typedef struct packed {
        logic clear_all;
        logic kill;
        logic set_prio;
        logic insert;
    } cell_cmd_t;

    function automatic logic needs_scan(input logic [2:0] op);
        return (op == OP_ENQUEUE) || (op == OP_DEQUEUE) || (op == OP_PEEK) ||
               (op == OP_CHANGE);
    endfunction

endpackage

/* hw/rtl/mpq_cell.sv */
`timescale 1ns / 1ps

module mpq_cell #(
    parameter int CELL_INDEX    = 0,
    parameter int IDX_W         = 6,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpq_pkg::cell_cmd_t                cmd,
    input  logic [IDX_W-1:0]                  cmd_idx,
    input  logic [TAG_BITS-1:0]               req_tag,
    input  logic [PRIORITY_BITS-1:0]         req_prio,
    input  logic [mpq_pkg::ARRIVAL_BITS-1:0] arrival_now,
    input  mpq_pkg::scan_flags_t              flags_in,
    input  logic [IDX_W-1:0]                  top_idx_in,
    input  logic [PRIORITY_BITS-1:0]         top_prio_in,
    input  logic [TAG_BITS-1:0]               top_tag_in,
    input  logic [mpq_pkg::ARRIVAL_BITS-1:0] top_age_in,
    input  logic [IDX_W-1:0]                  tag_idx_in,
    input  logic [mpq_pkg::ARRIVAL_BITS-1:0] tag_age_in,
    input  logic [IDX_W-1:0]                  free_idx_in,
    output mpq_pkg::scan_flags_t              flags_out,
    output logic [IDX_W-1:0]                  top_idx_out,
    output logic [PRIORITY_BITS-1:0]         top_prio_out,
    output logic [TAG_BITS-1:0]               top_tag_out,
    output logic [mpq_pkg::ARRIVAL_BITS-1:0] top_age_out,
    output logic [IDX_W-1:0]                  tag_idx_out,
    output logic [mpq_pkg::ARRIVAL_BITS-1:0] tag_age_out,
    output logic [IDX_W-1:0]                  free_idx_out
);
    import mpq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic                      live_reg;
    logic [TAG_BITS-1:0]       tag_reg;
    logic [PRIORITY_BITS-1:0]  prio_reg;
    logic [ARRIVAL_BITS-1:0]   arr_reg;

    logic                      hit;
    logic [ARRIVAL_BITS-1:0]   age;
    logic                      own_top;
    logic                      own_tag;
    logic                      own_free;

    scan_flags_t               flags_reg;
    scan_flags_t               flags_next;
    logic [IDX_W-1:0]          top_idx_reg;
    logic [PRIORITY_BITS-1:0]  top_prio_reg;
    logic [TAG_BITS-1:0]       top_tag_reg;
    logic [ARRIVAL_BITS-1:0]   top_age_reg;
    logic [IDX_W-1:0]          tag_idx_reg;
    logic [ARRIVAL_BITS-1:0]   tag_age_reg;
    logic [IDX_W-1:0]          free_idx_reg;

    assign hit = (cmd_idx == MY_IDX);
    assign age = arrival_now - arr_reg;

    // Lower priority wins; equal priority goes to the older entry, ties to lower slot.
    assign own_top = live_reg &&
                     (!flags_in.top_found || (prio_reg < top_prio_in) ||
                      ((prio_reg == top_prio_in) && (age > top_age_in)));
    assign own_tag = live_reg && (tag_reg == req_tag) &&
                     (!flags_in.tag_found || (age > tag_age_in));
    assign own_free = !live_reg && !flags_in.free_found;

    always_comb
    begin
        flags_next.valid      = flags_in.valid;
        flags_next.top_found  = flags_in.top_found || own_top;
        flags_next.tag_found  = flags_in.tag_found || own_tag;
        flags_next.free_found = flags_in.free_found || own_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (cmd.clear_all)
        begin
            live_reg <= 1'b0;
        end
        else if (hit && cmd.insert)
        begin
            live_reg <= 1'b1;
        end
        else if (hit && cmd.kill)
        begin
            live_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && cmd.insert)
        begin
            tag_reg  <= req_tag;
            prio_reg <= req_prio;
            arr_reg  <= arrival_now;
        end
        else if (hit && cmd.set_prio)
        begin
            prio_reg <= req_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_idx_reg  <= own_top ? MY_IDX : top_idx_in;
        top_prio_reg <= own_top ? prio_reg : top_prio_in;
        top_tag_reg  <= own_top ? tag_reg : top_tag_in;
        top_age_reg  <= own_top ? age : top_age_in;
        tag_idx_reg  <= own_tag ? MY_IDX : tag_idx_in;
        tag_age_reg  <= own_tag ? age : tag_age_in;
        free_idx_reg <= own_free ? MY_IDX : free_idx_in;
    end

    assign flags_out    = flags_reg;
    assign top_idx_out  = top_idx_reg;
    assign top_prio_out = top_prio_reg;
    assign top_tag_out  = top_tag_reg;
    assign top_age_out  = top_age_reg;
    assign tag_idx_out  = tag_idx_reg;
    assign tag_age_out  = tag_age_reg;
    assign free_idx_out = free_idx_reg;

endmodule

/* hw/rtl/min_priority_queue.sv */
`timescale 1ns / 1ps

// Min-priority queue of up to CAPACITY tagged entries, one operation per item.
// Each slot lives in its own cell; enqueue, dequeue, peek and change-priority
// send a search wave down the cell chain, one cell per cycle, which picks the
// most urgent entry (ties to the earliest arrival), the oldest entry with the
// requested tag and the lowest free slot. Such an item keeps the queue busy
// until the wave has walked the whole chain and its result has entered the
// output register; clear and unused codes skip the scan. A new item is
// accepted while the previous result still waits in the output register.
module min_priority_queue #(
    parameter int CAPACITY      = 64,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       operation,
    input  logic [TAG_BITS-1:0]              tag,
    input  logic [PRIORITY_BITS-1:0]         priority_req,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [TAG_BITS-1:0]              out_tag,
    output logic [PRIORITY_BITS-1:0]         out_priority,
    output logic [1:0]                       status,
    output logic [$clog2(CAPACITY+1)-1:0]    count
);
    import mpq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    state_t                    state_reg;
    state_t                    state_next;
    logic                      launch_reg;
    logic                      accept;
    logic                      finish_go;

    logic [2:0]                op_reg;
    logic [TAG_BITS-1:0]       tag_reg;
    logic [PRIORITY_BITS-1:0]  prio_reg;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [ARRIVAL_BITS-1:0]   arr_cnt_reg;
    logic [ARRIVAL_BITS-1:0]   arr_cnt_next;

    logic                      scan_top_found;
    logic                      scan_tag_found;
    logic                      scan_free_found;
    logic [IDX_W-1:0]          scan_top_idx;
    logic [PRIORITY_BITS-1:0]  scan_top_prio;
    logic [TAG_BITS-1:0]       scan_top_tag;
    logic [IDX_W-1:0]          scan_tag_idx;
    logic [IDX_W-1:0]          scan_free_idx;

    cell_cmd_t                 cmd;
    logic [IDX_W-1:0]          cmd_idx;
    logic [TAG_BITS-1:0]       res_tag;
    logic [PRIORITY_BITS-1:0]  res_prio;
    status_t                   res_status;
    logic                      full;
    logic                      empty;

    logic                      out_valid_reg;
    logic [TAG_BITS-1:0]       out_tag_reg;
    logic [PRIORITY_BITS-1:0]  out_prio_reg;
    logic [1:0]                out_status_reg;
    logic [CNT_W-1:0]          out_count_reg;

    scan_flags_t               flg      [0:CAPACITY];
    logic [IDX_W-1:0]          top_idx  [0:CAPACITY];
    logic [PRIORITY_BITS-1:0]  top_prio [0:CAPACITY];
    logic [TAG_BITS-1:0]       top_tag  [0:CAPACITY];
    logic [ARRIVAL_BITS-1:0]   top_age  [0:CAPACITY];
    logic [IDX_W-1:0]          tag_idx  [0:CAPACITY];
    logic [ARRIVAL_BITS-1:0]   tag_age  [0:CAPACITY];
    logic [IDX_W-1:0]          free_idx [0:CAPACITY];

    assign flg[0]      = scan_flags_t'({launch_reg, 3'b000});
    assign top_idx[0]  = '0;
    assign top_prio[0] = '0;
    assign top_tag[0]  = '0;
    assign top_age[0]  = '0;
    assign tag_idx[0]  = '0;
    assign tag_age[0]  = '0;
    assign free_idx[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        mpq_cell #(
            .CELL_INDEX    (i),
            .IDX_W         (IDX_W),
            .TAG_BITS      (TAG_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .cmd_idx      (cmd_idx),
            .req_tag      (tag_reg),
            .req_prio     (prio_reg),
            .arrival_now  (arr_cnt_reg),
            .flags_in     (flg[i]),
            .top_idx_in   (top_idx[i]),
            .top_prio_in  (top_prio[i]),
            .top_tag_in   (top_tag[i]),
            .top_age_in   (top_age[i]),
            .tag_idx_in   (tag_idx[i]),
            .tag_age_in   (tag_age[i]),
            .free_idx_in  (free_idx[i]),
            .flags_out    (flg[i+1]),
            .top_idx_out  (top_idx[i+1]),
            .top_prio_out (top_prio[i+1]),
            .top_tag_out  (top_tag[i+1]),
            .top_age_out  (top_age[i+1]),
            .tag_idx_out  (tag_idx[i+1]),
            .tag_age_out  (tag_age[i+1]),
            .free_idx_out (free_idx[i+1])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = needs_scan(operation) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (flg[CAPACITY].valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign full      = (count_reg == FULL_COUNT);
    assign empty     = (count_reg == '0);

    always_comb
    begin
        cmd          = '0;
        cmd_idx      = '0;
        res_tag      = '0;
        res_prio     = '0;
        res_status   = STAT_OK;
        count_next   = count_reg;
        arr_cnt_next = arr_cnt_reg;
        if (finish_go)
        begin
            case (op_reg)
                OP_ENQUEUE:
                begin
                    if (full)
                    begin
                        res_status = STAT_FULL;
                    end
                    else
                    begin
                        cmd.insert   = 1'b1;
                        cmd_idx      = scan_free_idx;
                        count_next   = count_reg + CNT_W'(1);
                        arr_cnt_next = arr_cnt_reg + ARRIVAL_BITS'(1);
                    end
                end
                OP_DEQUEUE, OP_PEEK:
                begin
                    if (empty)
                    begin
                        res_status = STAT_EMPTY;
                    end
                    else
                    begin
                        res_tag  = scan_top_tag;
                        res_prio = scan_top_prio;
                        if (op_reg == OP_DEQUEUE)
                        begin
                            cmd.kill   = 1'b1;
                            cmd_idx    = scan_top_idx;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                OP_CHANGE:
                begin
                    if (empty)
                    begin
                        res_status = STAT_EMPTY;
                    end
                    else if (!scan_tag_found)
                    begin
                        res_status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.set_prio = 1'b1;
                        cmd_idx      = scan_tag_idx;
                    end
                end
                OP_CLEAR:
                begin
                    cmd.clear_all = 1'b1;
                    count_next    = '0;
                    arr_cnt_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            count_reg     <= '0;
            arr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            launch_reg  <= accept && needs_scan(operation);
            count_reg   <= count_next;
            arr_cnt_reg <= arr_cnt_next;
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            tag_reg  <= tag;
            prio_reg <= priority_req;
        end
        if ((state_reg == ST_SCAN) && flg[CAPACITY].valid)
        begin
            scan_top_found  <= flg[CAPACITY].top_found;
            scan_tag_found  <= flg[CAPACITY].tag_found;
            scan_free_found <= flg[CAPACITY].free_found;
            scan_top_idx    <= top_idx[CAPACITY];
            scan_top_prio   <= top_prio[CAPACITY];
            scan_top_tag    <= top_tag[CAPACITY];
            scan_tag_idx    <= tag_idx[CAPACITY];
            scan_free_idx   <= free_idx[CAPACITY];
        end
        if (finish_go)
        begin
            out_tag_reg    <= res_tag;
            out_prio_reg   <= res_prio;
            out_status_reg <= res_status;
            out_count_reg  <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_prio_reg;
    assign status       = out_status_reg;
    assign count        = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("live count above capacity");

    a_wave_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        flg[CAPACITY].valid |-> (state_reg == ST_SCAN))
        else $error("search wave ended outside scan");

    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && (op_reg == OP_ENQUEUE) && !full) |-> scan_free_found)
        else $error("no free slot although queue not full");

    a_top_found: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && ((op_reg == OP_DEQUEUE) || (op_reg == OP_PEEK)) && !empty)
        |-> scan_top_found)
        else $error("no live entry although count is nonzero");
`endif

endmodule
